// ===== rtl/abiw_pkg.sv =====
// ----------------------------------------------------------------------------
// abiw_pkg
// Shared types and constants of the affine backward image warp.
// ----------------------------------------------------------------------------
package abiw_pkg;

   localparam int COEF_W  = 32;   // signed Q16.16 gains and offsets
   localparam int DT_W    = 24;   // unsigned Q8.16 frame interval
   localparam int COORD_W = 8;    // request row and column
   localparam int PIX_W   = 16;   // pixel sample
   localparam int SRC_W   = 37;   // signed source coordinate
   localparam int REG_W   = 3;    // register index

   localparam logic [DT_W-1:0] DT_RESET = DT_W'(65536);

   typedef enum logic [REG_W-1:0] {
      REG_ROW_GAIN_ROW   = 3'd0,
      REG_ROW_GAIN_COL   = 3'd1,
      REG_ROW_OFFSET     = 3'd2,
      REG_COL_GAIN_ROW   = 3'd3,
      REG_COL_GAIN_COL   = 3'd4,
      REG_COL_OFFSET     = 3'd5,
      REG_FRAME_INTERVAL = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] row_gain_row;
      logic signed [COEF_W-1:0] row_gain_col;
      logic signed [COEF_W-1:0] row_offset;
      logic signed [COEF_W-1:0] col_gain_row;
      logic signed [COEF_W-1:0] col_gain_col;
      logic signed [COEF_W-1:0] col_offset;
      logic [DT_W-1:0]          frame_interval;
   } coef_type;

   typedef struct packed {
      logic               valid;
      logic               warp;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   value;
   } item_type;

endpackage

// ===== rtl/abiw_csr.sv =====
// ----------------------------------------------------------------------------
// abiw_csr
// Warp coefficient and frame interval registers behind the csr write channel.
// ----------------------------------------------------------------------------
module abiw_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [abiw_pkg::REG_W-1:0]    csr_index,
   input  logic [abiw_pkg::COEF_W-1:0]   csr_data,
   output abiw_pkg::coef_type            coef
);

   abiw_pkg::coef_type coef_ff;
   abiw_pkg::coef_type coef_in;

   assign csr_ready = 1'b1;
   assign coef      = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         case (abiw_pkg::reg_index_type'(csr_index))
            abiw_pkg::REG_ROW_GAIN_ROW:   coef_in.row_gain_row = $signed(csr_data);
            abiw_pkg::REG_ROW_GAIN_COL:   coef_in.row_gain_col = $signed(csr_data);
            abiw_pkg::REG_ROW_OFFSET:     coef_in.row_offset   = $signed(csr_data);
            abiw_pkg::REG_COL_GAIN_ROW:   coef_in.col_gain_row = $signed(csr_data);
            abiw_pkg::REG_COL_GAIN_COL:   coef_in.col_gain_col = $signed(csr_data);
            abiw_pkg::REG_COL_OFFSET:     coef_in.col_offset   = $signed(csr_data);
            abiw_pkg::REG_FRAME_INTERVAL: begin
               coef_in.frame_interval = csr_data[abiw_pkg::DT_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // gains and offsets clear, frame interval is the lowest field
         coef_ff <= abiw_pkg::coef_type'({{(6 * abiw_pkg::COEF_W){1'b0}},
                                          abiw_pkg::DT_RESET});
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

// ===== rtl/abiw_axis.sv =====
// ----------------------------------------------------------------------------
// abiw_axis
// Six-stage source coordinate pipeline for one axis:
// base - trunc(dt * (gain_row*row + gain_col*col + offset)), toward zero.
// ----------------------------------------------------------------------------
module abiw_axis (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [abiw_pkg::COORD_W-1:0]        row,
   input  logic [abiw_pkg::COORD_W-1:0]        col,
   input  logic [abiw_pkg::COORD_W-1:0]        base,
   input  logic signed [abiw_pkg::COEF_W-1:0]  gain_row,
   input  logic signed [abiw_pkg::COEF_W-1:0]  gain_col,
   input  logic signed [abiw_pkg::COEF_W-1:0]  offset,
   input  logic [abiw_pkg::DT_W-1:0]           dt,
   output logic signed [abiw_pkg::SRC_W-1:0]   src
);

   localparam int PROD_W = abiw_pkg::COEF_W + abiw_pkg::COORD_W + 1;
   localparam int SUM_W  = PROD_W + 1;
   localparam int HI_W   = SUM_W - 16 + abiw_pkg::DT_W;
   localparam int LO_W   = 16 + abiw_pkg::DT_W;
   localparam int ACC_W  = HI_W + 1;
   localparam int Q_W    = ACC_W - 16;
   localparam int DLY    = 5;

   logic signed [PROD_W-1:0] prod_row_ff, prod_row_in;
   logic signed [PROD_W-1:0] prod_col_ff, prod_col_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff;
   logic                     neg_mul_ff;
   logic [HI_W-1:0]          hi_ff, hi_in;
   logic [LO_W-1:0]          lo_ff, lo_in;
   logic [ACC_W-1:0]         acc;
   logic [Q_W-1:0]           quot;
   logic signed [Q_W:0]      disp_ff, disp_in;
   logic signed [abiw_pkg::SRC_W-1:0] src_ff, src_in;
   logic [abiw_pkg::COORD_W-1:0] base_dly_ff [DLY];

   assign prod_row_in = gain_row * $signed({1'b0, row});
   assign prod_col_in = gain_col * $signed({1'b0, col});
   assign sum_in      = SUM_W'(prod_row_ff) + SUM_W'(prod_col_ff) + SUM_W'(offset);
   assign mag_in      = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   // magnitude split at bit 16 keeps both multipliers narrow
   assign hi_in       = HI_W'(mag_ff[SUM_W-1:16]) * HI_W'(dt);
   assign lo_in       = LO_W'(mag_ff[15:0]) * LO_W'(dt);
   assign acc         = ACC_W'(hi_ff) + ACC_W'(lo_ff[LO_W-1:16]);
   assign quot        = acc[ACC_W-1:16];
   assign disp_in     = neg_mul_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   assign src_in      = $signed(abiw_pkg::SRC_W'({1'b0, base_dly_ff[DLY-1]}))
                        - abiw_pkg::SRC_W'(disp_ff);
   assign src         = src_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_row_ff    <= prod_row_in;
         prod_col_ff    <= prod_col_in;
         sum_ff         <= sum_in;
         mag_ff         <= mag_in;
         neg_ff         <= sum_ff[SUM_W-1];
         hi_ff          <= hi_in;
         lo_ff          <= lo_in;
         neg_mul_ff     <= neg_ff;
         disp_ff        <= disp_in;
         src_ff         <= src_in;
         base_dly_ff[0] <= base;
         for (int i = 1; i < DLY; i++) begin
            base_dly_ff[i] <= base_dly_ff[i-1];
         end
      end
   end

endmodule

// ===== rtl/abiw_fstore.sv =====
// ----------------------------------------------------------------------------
// abiw_fstore
// Frame store: one write port for pixel loads, one registered read port.
// ----------------------------------------------------------------------------
module abiw_fstore #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16
) (
   input  logic                       clock,
   input  logic                       advance,
   input  logic                       wr_en,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          addr,
   input  logic [abiw_pkg::PIX_W-1:0] wr_data,
   output logic [abiw_pkg::PIX_W-1:0] rd_data
);

   logic [abiw_pkg::PIX_W-1:0] mem [DEPTH];
   logic [abiw_pkg::PIX_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (advance && wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

endmodule

// ===== rtl/affine_backward_image_warp.sv =====
// ----------------------------------------------------------------------------
// affine_backward_image_warp
// Nearest-neighbor affine backward warp over a frame store.
// ----------------------------------------------------------------------------
// Usage: write the six Q16.16 coefficients and the Q8.16 frame interval on
// the csr channel while the block is idle, load the source frame with
// req_tuser = 0 transfers (one pixel each, none answered), then send
// req_tuser = 1 transfers naming output pixels. Each warp returns one rsp
// transfer with the fetched sample, or zero with rsp_tuser set when the
// source position falls outside the frame.
// Throughput: one item per cycle while no held result stalls the pipeline.
// A req transfer reaches its rsp transfer through the six-stage coordinate
// pipeline (products, sum, magnitude, dt multiply, truncation, subtract),
// the bounds and address stage and the registered frame store read.
// All stages advance together; when rsp_tready is low with a result held, req_tready
// drops and every stage holds its contents. Reset clears the pipeline valid bits and
// the registers (frame interval to 1.0); the frame store is not cleared, and it is to
// be read only after the user has loaded it, which the block does not enforce.
// ----------------------------------------------------------------------------
module affine_backward_image_warp #(
   parameter int FRAME_HEIGHT = 256,
   parameter int FRAME_WIDTH  = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   // config write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [abiw_pkg::REG_W-1:0]    csr_index,
   input  logic [abiw_pkg::COEF_W-1:0]   csr_data,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,  // pixel_row, pixel_col, load_value
   input  logic                          req_tuser,  // func
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,  // warped_value
   output logic                          rsp_tuser   // out_of_bounds
);

   localparam int DEPTH  = FRAME_HEIGHT * FRAME_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RW     = $clog2(FRAME_HEIGHT);
   localparam int CW     = $clog2(FRAME_WIDTH);
   localparam int NCTRL  = 6;
   localparam int SW     = abiw_pkg::SRC_W;

   abiw_pkg::coef_type coef;
   abiw_pkg::item_type req_item;
   abiw_pkg::item_type ctrl_ff [NCTRL];
   abiw_pkg::item_type tail;

   logic                  advance;
   logic signed [SW-1:0]  src_row, src_col;
   logic signed [SW-1:0]  sel_row, sel_col;
   logic                  in_frame;
   logic [ADDR_W-1:0]     addr_in;

   logic                  s7_valid_ff;
   logic                  s7_warp_ff;
   logic                  s7_oob_ff;
   logic                  s7_we_ff;
   logic                  s7_re_ff;
   logic [ADDR_W-1:0]     s7_addr_ff;
   logic [abiw_pkg::PIX_W-1:0] s7_value_ff;
   logic                  s8_valid_ff;
   logic                  s8_oob_ff;
   logic [abiw_pkg::PIX_W-1:0] rd_data;

   assign advance    = !s8_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      req_item.valid = req_tvalid;
      req_item.warp  = req_tuser;
      req_item.row   = req_tdata[7:0];
      req_item.col   = req_tdata[15:8];
      req_item.value = req_tdata[31:16];
   end

   abiw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   abiw_axis u_row_axis (
      .clock    (clock),
      .advance  (advance),
      .row      (req_item.row),
      .col      (req_item.col),
      .base     (req_item.row),
      .gain_row (coef.row_gain_row),
      .gain_col (coef.row_gain_col),
      .offset   (coef.row_offset),
      .dt       (coef.frame_interval),
      .src      (src_row)
   );

   abiw_axis u_col_axis (
      .clock    (clock),
      .advance  (advance),
      .row      (req_item.row),
      .col      (req_item.col),
      .base     (req_item.col),
      .gain_row (coef.col_gain_row),
      .gain_col (coef.col_gain_col),
      .offset   (coef.col_offset),
      .dt       (coef.frame_interval),
      .src      (src_col)
   );

   // control travels alongside the coordinate pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCTRL; i++) begin
            ctrl_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         ctrl_ff[0] <= req_item;
         for (int i = 1; i < NCTRL; i++) begin
            ctrl_ff[i] <= ctrl_ff[i-1];
         end
      end
   end

   assign tail = ctrl_ff[NCTRL-1];

   // loads address the store with their own row and column
   always_comb begin
      sel_row  = tail.warp ? src_row : $signed(SW'({1'b0, tail.row}));
      sel_col  = tail.warp ? src_col : $signed(SW'({1'b0, tail.col}));
      in_frame = (sel_row >= 0) && (sel_row < $signed(SW'(FRAME_HEIGHT)))
                 && (sel_col >= 0) && (sel_col < $signed(SW'(FRAME_WIDTH)));
      addr_in  = ADDR_W'(ADDR_W'(sel_row[RW-1:0]) * ADDR_W'(FRAME_WIDTH))
                 + ADDR_W'(sel_col[CW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else if (advance) begin
         s7_valid_ff <= tail.valid;
         s8_valid_ff <= s7_valid_ff && s7_warp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_warp_ff  <= tail.warp;
         s7_oob_ff   <= !in_frame;
         s7_we_ff    <= tail.valid && !tail.warp && in_frame;
         s7_re_ff    <= tail.valid && tail.warp && in_frame;
         s7_addr_ff  <= addr_in;
         s7_value_ff <= tail.value;
         s8_oob_ff   <= s7_oob_ff;
      end
   end

   abiw_fstore #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_fstore (
      .clock   (clock),
      .advance (advance),
      .wr_en   (s7_we_ff),
      .rd_en   (s7_re_ff),
      .addr    (s7_addr_ff),
      .wr_data (s7_value_ff),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = s8_valid_ff;
   assign rsp_tdata  = s8_oob_ff ? '0 : rd_data;
   assign rsp_tuser  = s8_oob_ff;

endmodule
